@@ design/x25519_scalar_multiply_defines.svh @@
// Assertion macros shared by the X25519 scalar multiply design.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef X25519_SCALAR_MULTIPLY_DEFINES_SVH
`define X25519_SCALAR_MULTIPLY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define X25_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define X25_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ design/x25_pkg.sv @@
// Types, constants and microcode for the X25519 scalar multiply block.
// Depends on nothing; used by x25_fe_unit and the top level.
`timescale 1ns / 1ps

package x25_pkg;

    typedef logic [255:0] fe_t;

    // p = 2^255 - 19
    localparam fe_t PRIME = {1'b0, {247{1'b1}}, 8'hED};
    localparam fe_t A24   = 256'd121665;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } fe_ctrl_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] dst;
        logic [3:0] sa;
        logic [3:0] sb;
        logic       last;
    } instr_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_EXEC,
        S_WAIT,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_INIT,
        PH_LADDER,
        PH_INV1,
        PH_SQR,
        PH_MULZ,
        PH_FINAL
    } phase_t;

    // Register file addresses; 12 and up are constant or input sources.
    localparam logic [3:0] R_BASE  = 4'd0;
    localparam logic [3:0] R_T0    = 4'd1;
    localparam logic [3:0] R_T1    = 4'd2;
    localparam logic [3:0] R_T2    = 4'd3;
    localparam logic [3:0] R_PX    = 4'd4;
    localparam logic [3:0] R_PZ    = 4'd5;
    localparam logic [3:0] R_QX    = 4'd6;
    localparam logic [3:0] R_QZ    = 4'd7;
    localparam logic [3:0] R_T3    = 4'd8;
    localparam logic [3:0] R_T4    = 4'd9;
    localparam logic [3:0] R_T5    = 4'd10;
    localparam logic [3:0] R_T6    = 4'd11;
    localparam logic [3:0] R_ZERO  = 4'd12;
    localparam logic [3:0] R_ONE   = 4'd13;
    localparam logic [3:0] R_A24   = 4'd14;
    localparam logic [3:0] R_POINT = 4'd15;

    localparam logic [4:0] PC_STEP = 5'd12;

    function automatic instr_t mk(input op_t op, input logic [3:0] dst,
                                  input logic [3:0] sa, input logic [3:0] sb,
                                  input logic last);
        instr_t r;
        r.op   = op;
        r.dst  = dst;
        r.sa   = sa;
        r.sb   = sb;
        r.last = last;
        return r;
    endfunction

    // Setup (base reduce, Q = 2P, P = (x:1)) then one ladder step. In the step,
    // P names the point that receives the sum and Q the one that is doubled.
    function automatic instr_t ucode(input logic [4:0] pc);
        instr_t r;
        case (pc)
            5'd0:  r = mk(OP_ADD, R_BASE, R_POINT, R_ZERO, 1'b0);
            5'd1:  r = mk(OP_ADD, R_T0, R_BASE, R_ONE, 1'b0);
            5'd2:  r = mk(OP_SUB, R_T1, R_BASE, R_ONE, 1'b0);
            5'd3:  r = mk(OP_MUL, R_T0, R_T0, R_T0, 1'b0);
            5'd4:  r = mk(OP_MUL, R_T1, R_T1, R_T1, 1'b0);
            5'd5:  r = mk(OP_SUB, R_T2, R_T0, R_T1, 1'b0);
            5'd6:  r = mk(OP_MUL, R_QX, R_T0, R_T1, 1'b0);
            5'd7:  r = mk(OP_MUL, R_T3, R_A24, R_T2, 1'b0);
            5'd8:  r = mk(OP_ADD, R_T3, R_T0, R_T3, 1'b0);
            5'd9:  r = mk(OP_MUL, R_QZ, R_T2, R_T3, 1'b0);
            5'd10: r = mk(OP_ADD, R_PX, R_BASE, R_ZERO, 1'b0);
            5'd11: r = mk(OP_ADD, R_PZ, R_ONE, R_ZERO, 1'b1);
            5'd12: r = mk(OP_SUB, R_T4, R_PX, R_PZ, 1'b0);
            5'd13: r = mk(OP_ADD, R_T5, R_QX, R_QZ, 1'b0);
            5'd14: r = mk(OP_MUL, R_T4, R_T4, R_T5, 1'b0);
            5'd15: r = mk(OP_ADD, R_T5, R_PX, R_PZ, 1'b0);
            5'd16: r = mk(OP_SUB, R_T6, R_QX, R_QZ, 1'b0);
            5'd17: r = mk(OP_MUL, R_T5, R_T5, R_T6, 1'b0);
            5'd18: r = mk(OP_ADD, R_T6, R_T4, R_T5, 1'b0);
            5'd19: r = mk(OP_SUB, R_T4, R_T4, R_T5, 1'b0);
            5'd20: r = mk(OP_ADD, R_T0, R_QX, R_QZ, 1'b0);
            5'd21: r = mk(OP_SUB, R_T1, R_QX, R_QZ, 1'b0);
            5'd22: r = mk(OP_MUL, R_T0, R_T0, R_T0, 1'b0);
            5'd23: r = mk(OP_MUL, R_T1, R_T1, R_T1, 1'b0);
            5'd24: r = mk(OP_SUB, R_T2, R_T0, R_T1, 1'b0);
            5'd25: r = mk(OP_MUL, R_QX, R_T0, R_T1, 1'b0);
            5'd26: r = mk(OP_MUL, R_T3, R_A24, R_T2, 1'b0);
            5'd27: r = mk(OP_ADD, R_T3, R_T0, R_T3, 1'b0);
            5'd28: r = mk(OP_MUL, R_QZ, R_T2, R_T3, 1'b0);
            5'd29: r = mk(OP_MUL, R_PX, R_T6, R_T6, 1'b0);
            5'd30: r = mk(OP_MUL, R_T4, R_T4, R_T4, 1'b0);
            5'd31: r = mk(OP_MUL, R_PZ, R_T4, R_BASE, 1'b1);
            default: r = mk(OP_ADD, R_T0, R_ZERO, R_ZERO, 1'b1);
        endcase
        return r;
    endfunction

endpackage

@@ design/x25519_scalar_multiply.sv @@
// X25519 scalar multiply: Montgomery ladder then p-2 power inverse, mod 2^255-19.
// After the index-3 beat it scans down from bit 255 for the top set scalar bit,
// then runs the ladder over the lower bits and the inverse. The bit-serial
// multiplier sets the pace of both; the block takes one computation at a time.
// Asynchronous active-low reset returns control to idle; stored words and
// working registers are not cleared.
`timescale 1ns / 1ps
`include "x25519_scalar_multiply_defines.svh"

module x25519_scalar_multiply
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] point_word,
    input  logic [63:0] scalar_word,
    input  logic [1:0]  word_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_word,
    output logic [1:0]  result_index,
    output logic        result_last
);

    // Control registers and their next values.
    x25_pkg::state_t state_reg;
    x25_pkg::state_t state_next;
    x25_pkg::phase_t phase_reg;
    x25_pkg::phase_t phase_next;
    logic [4:0]      pc_reg;
    logic [4:0]      pc_next;
    logic [7:0]      bit_reg;
    logic [7:0]      bit_next;
    logic [1:0]      ocnt_reg;
    logic [1:0]      ocnt_next;

    // Loaded operands, working register file and result.
    x25_pkg::fe_t    point_reg;
    logic [255:0]    scalar_reg;
    x25_pkg::fe_t    mem [0:11];
    x25_pkg::fe_t    opa_reg;
    x25_pkg::fe_t    opb_reg;
    logic [3:0]      dst_reg;
    x25_pkg::fe_t    res_reg;

    x25_pkg::instr_t   instr;
    logic              swap;
    logic [3:0]        sa_m;
    logic [3:0]        sb_m;
    logic [3:0]        dst_m;
    x25_pkg::fe_ctrl_t fe_ctrl;
    logic              fe_done;
    x25_pkg::fe_t      fe_result;
    logic              in_acc;

    // In a ladder step the roles of P and Q follow the current scalar bit:
    // for a zero bit, Q takes the sum and P is doubled.
    function automatic logic [3:0] remap(input logic [3:0] a, input logic sw);
        return (sw && a[3:2] == 2'b01) ? (a ^ 4'b0010) : a;
    endfunction

    assign in_acc = in_valid && !in_stall;

    always_comb
    begin
        case (phase_reg)
            x25_pkg::PH_INIT,
            x25_pkg::PH_LADDER:
                instr = x25_pkg::ucode(pc_reg);
            x25_pkg::PH_INV1:
                instr = x25_pkg::mk(x25_pkg::OP_ADD, x25_pkg::R_T0, x25_pkg::R_ONE,
                                    x25_pkg::R_ZERO, 1'b1);
            x25_pkg::PH_SQR:
                instr = x25_pkg::mk(x25_pkg::OP_MUL, x25_pkg::R_T0, x25_pkg::R_T0,
                                    x25_pkg::R_T0, 1'b1);
            x25_pkg::PH_MULZ:
                instr = x25_pkg::mk(x25_pkg::OP_MUL, x25_pkg::R_T0, x25_pkg::R_T0,
                                    x25_pkg::R_PZ, 1'b1);
            default:
                instr = x25_pkg::mk(x25_pkg::OP_MUL, x25_pkg::R_T1, x25_pkg::R_PX,
                                    x25_pkg::R_T0, 1'b1);
        endcase
        swap  = (phase_reg == x25_pkg::PH_LADDER) && !scalar_reg[bit_reg];
        sa_m  = remap(instr.sa, swap);
        sb_m  = remap(instr.sb, swap);
        dst_m = remap(instr.dst, swap);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= x25_pkg::S_IDLE;
            phase_reg <= x25_pkg::PH_INIT;
            pc_reg    <= 5'd0;
            bit_reg   <= 8'd0;
            ocnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pc_reg    <= pc_next;
            bit_reg   <= bit_next;
            ocnt_reg  <= ocnt_next;
        end
    end

    // Sequencer: scan for the top scalar bit, run the microcode and the
    // inverse chain one field operation at a time, then send four beats.
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        pc_next       = pc_reg;
        bit_next      = bit_reg;
        ocnt_next     = ocnt_reg;
        fe_ctrl.start = 1'b0;
        fe_ctrl.op    = instr.op;
        in_stall      = 1'b1;
        out_valid     = 1'b0;
        case (state_reg)
            x25_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && word_index == 2'd3)
                begin
                    state_next = x25_pkg::S_SCAN;
                    bit_next   = 8'd255;
                end
            end
            x25_pkg::S_SCAN:
            begin
                if (scalar_reg[bit_reg])
                begin
                    state_next = x25_pkg::S_FETCH;
                    phase_next = x25_pkg::PH_INIT;
                    pc_next    = 5'd0;
                end
                else if (bit_reg == 8'd0)
                begin
                    state_next = x25_pkg::S_OUT;
                    ocnt_next  = 2'd0;
                end
                else
                begin
                    bit_next = bit_reg - 8'd1;
                end
            end
            x25_pkg::S_FETCH:
            begin
                state_next = x25_pkg::S_EXEC;
            end
            x25_pkg::S_EXEC:
            begin
                fe_ctrl.start = 1'b1;
                state_next    = x25_pkg::S_WAIT;
            end
            x25_pkg::S_WAIT:
            begin
                if (fe_done)
                begin
                    state_next = x25_pkg::S_FETCH;
                    case (phase_reg)
                        x25_pkg::PH_INIT,
                        x25_pkg::PH_LADDER:
                        begin
                            if (!instr.last)
                            begin
                                pc_next = pc_reg + 5'd1;
                            end
                            else if (bit_reg == 8'd0)
                            begin
                                phase_next = x25_pkg::PH_INV1;
                            end
                            else
                            begin
                                phase_next = x25_pkg::PH_LADDER;
                                bit_next   = bit_reg - 8'd1;
                                pc_next    = x25_pkg::PC_STEP;
                            end
                        end
                        x25_pkg::PH_INV1:
                        begin
                            phase_next = x25_pkg::PH_SQR;
                            bit_next   = 8'd254;
                        end
                        x25_pkg::PH_SQR:
                        begin
                            // p-2 has every bit set below 255 except bits 2 and 4.
                            if (bit_reg != 8'd2 && bit_reg != 8'd4)
                            begin
                                phase_next = x25_pkg::PH_MULZ;
                            end
                            else
                            begin
                                bit_next = bit_reg - 8'd1;
                            end
                        end
                        x25_pkg::PH_MULZ:
                        begin
                            if (bit_reg == 8'd0)
                            begin
                                phase_next = x25_pkg::PH_FINAL;
                            end
                            else
                            begin
                                phase_next = x25_pkg::PH_SQR;
                                bit_next   = bit_reg - 8'd1;
                            end
                        end
                        default:
                        begin
                            state_next = x25_pkg::S_OUT;
                            ocnt_next  = 2'd0;
                        end
                    endcase
                end
            end
            x25_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    ocnt_next = ocnt_reg + 2'd1;
                    if (ocnt_reg == 2'd3)
                    begin
                        state_next = x25_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = x25_pkg::S_IDLE;
            end
        endcase
    end

    // Operand stores, register file and result word; no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            point_reg[{word_index, 6'b0} +: 64]  <= point_word;
            scalar_reg[{word_index, 6'b0} +: 64] <= scalar_word;
        end
        if (state_reg == x25_pkg::S_FETCH)
        begin
            dst_reg <= dst_m;
            case (sa_m)
                x25_pkg::R_ZERO:  opa_reg <= '0;
                x25_pkg::R_ONE:   opa_reg <= 256'd1;
                x25_pkg::R_A24:   opa_reg <= x25_pkg::A24;
                x25_pkg::R_POINT: opa_reg <= point_reg;
                default:          opa_reg <= mem[sa_m];
            endcase
            case (sb_m)
                x25_pkg::R_ZERO:  opb_reg <= '0;
                x25_pkg::R_ONE:   opb_reg <= 256'd1;
                x25_pkg::R_A24:   opb_reg <= x25_pkg::A24;
                x25_pkg::R_POINT: opb_reg <= point_reg;
                default:          opb_reg <= mem[sb_m];
            endcase
        end
        if (state_reg == x25_pkg::S_WAIT && fe_done)
        begin
            mem[dst_reg] <= fe_result;
            if (phase_reg == x25_pkg::PH_FINAL)
            begin
                res_reg <= fe_result;
            end
        end
        // A zero scalar gives a zero result.
        if (state_reg == x25_pkg::S_SCAN && !scalar_reg[bit_reg] && bit_reg == 8'd0)
        begin
            res_reg <= '0;
        end
    end

    x25_fe_unit u_fe
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (fe_ctrl),
        .opa    (opa_reg),
        .opb    (opb_reg),
        .done   (fe_done),
        .result (fe_result)
    );

    assign result_word  = res_reg[{ocnt_reg, 6'b0} +: 64];
    assign result_index = ocnt_reg;
    assign result_last  = (ocnt_reg == 2'd3);

    // The top result beat is below 2^63 since the value is reduced below p.
    `X25_ASSERT_IMP(a_top_reduced, out_valid && result_last, !result_word[63],
                    "top result word not reduced")
    // A start beat takes the block busy at once.
    `X25_ASSERT_NXT(a_start_busy, in_acc && word_index == 2'd3, in_stall,
                    "start beat did not begin computing")
    // After the last result beat is taken no beat follows at once.
    `X25_ASSERT_NXT(a_last_ends, out_valid && !out_stall && result_last, !out_valid,
                    "result beat after the last one")
    // The field unit finishes only when the sequencer waits for it.
    `X25_ASSERT_IMP(a_done_waits, fe_done, state_reg == x25_pkg::S_WAIT,
                    "field unit done outside wait")

endmodule

@@ design/x25_fe_unit.sv @@
// Field arithmetic unit mod 2^255-19: registered add and subtract, and a
// bit-serial multiplier taking one bit of the first operand per cycle.
// Depends on x25_pkg.
`timescale 1ns / 1ps

module x25_fe_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  x25_pkg::fe_ctrl_t ctrl,
    input  x25_pkg::fe_t      opa,
    input  x25_pkg::fe_t      opb,
    output logic              done,
    output x25_pkg::fe_t      result
);

    logic         busy_reg;
    logic         done_reg;
    logic [7:0]   cnt_reg;
    x25_pkg::fe_t a_reg;
    x25_pkg::fe_t b_reg;
    x25_pkg::fe_t acc_reg;
    x25_pkg::fe_t acc_next;
    x25_pkg::fe_t res_reg;
    x25_pkg::fe_t add_res;
    x25_pkg::fe_t sub_res;
    logic [256:0] add_sum;
    logic [256:0] sub_dif;
    logic [256:0] mul_sum;

    // Brings a value below 3p into [0, p).
    function automatic x25_pkg::fe_t reduce3(input logic [256:0] t);
        logic [257:0] d1;
        logic [257:0] d2;
        x25_pkg::fe_t r;
        d1 = {1'b0, t} - {2'b00, x25_pkg::PRIME};
        d2 = {1'b0, t} - {1'b0, x25_pkg::PRIME, 1'b0};
        if (!d2[257])
        begin
            r = d2[255:0];
        end
        else if (!d1[257])
        begin
            r = d1[255:0];
        end
        else
        begin
            r = t[255:0];
        end
        return r;
    endfunction

    always_comb
    begin
        add_sum = {1'b0, opa} + {1'b0, opb};
        add_res = reduce3(add_sum);
        sub_dif = {1'b0, opa} - {1'b0, opb};
        sub_res = sub_dif[256] ? (sub_dif[255:0] + x25_pkg::PRIME) : sub_dif[255:0];
        mul_sum = {acc_reg, 1'b0} + (a_reg[254] ? {1'b0, b_reg} : 257'd0);
        acc_next = reduce3(mul_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 8'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                if (ctrl.op == x25_pkg::OP_MUL)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 8'd254;
                end
                else
                begin
                    done_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 8'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            case (ctrl.op)
                x25_pkg::OP_ADD: res_reg <= add_res;
                x25_pkg::OP_SUB: res_reg <= sub_res;
                default:
                begin
                    acc_reg <= '0;
                    a_reg   <= opa;
                    b_reg   <= opb;
                end
            endcase
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            a_reg   <= {a_reg[254:0], 1'b0};
            if (cnt_reg == 8'd0)
            begin
                res_reg <= acc_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ sim/x25519_result_checker.sv @@
// Result checker for the X25519 scalar multiply block: mirrors the loaded words,
// predicts the four result beats of each computation and compares them. Uses x25_pkg.
`timescale 1ns / 1ps

module x25519_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [63:0] point_word,
    input  logic [63:0] scalar_word,
    input  logic [1:0]  word_index,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] result_word,
    input  logic [1:0]  result_index,
    input  logic        result_last,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [63:0] word;
        logic [1:0]  index;
        logic        last;
    } result_beat_t;

    result_beat_t expected_beats[$];
    logic [63:0]  point_words[4];
    logic [63:0]  scalar_words[4];

    function automatic x25_pkg::fe_t fe_add_mod(x25_pkg::fe_t a, x25_pkg::fe_t b);
        logic [256:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, x25_pkg::PRIME})
            s = s - {1'b0, x25_pkg::PRIME};
        return s[255:0];
    endfunction

    function automatic x25_pkg::fe_t fe_sub_mod(x25_pkg::fe_t a, x25_pkg::fe_t b);
        logic [256:0] s;
        s = {1'b0, a} + {1'b0, x25_pkg::PRIME} - {1'b0, b};
        if (s >= {1'b0, x25_pkg::PRIME})
            s = s - {1'b0, x25_pkg::PRIME};
        return s[255:0];
    endfunction

    function automatic x25_pkg::fe_t fe_mul_mod(x25_pkg::fe_t a, x25_pkg::fe_t b);
        logic [511:0] w;
        w = {256'd0, a} * {256'd0, b};
        w = w % {256'd0, x25_pkg::PRIME};
        return w[255:0];
    endfunction

    function automatic void point_double(output x25_pkg::fe_t ox, output x25_pkg::fe_t oz,
                                         input x25_pkg::fe_t x, input x25_pkg::fe_t z);
        x25_pkg::fe_t ss, dd, e;
        ss = fe_add_mod(x, z);
        ss = fe_mul_mod(ss, ss);
        dd = fe_sub_mod(x, z);
        dd = fe_mul_mod(dd, dd);
        e  = fe_sub_mod(ss, dd);
        ox = fe_mul_mod(ss, dd);
        oz = fe_mul_mod(e, fe_add_mod(ss, fe_mul_mod(x25_pkg::A24, e)));
    endfunction

    // a receives a + b (their difference is the base point), b is doubled.
    function automatic void ladder_rung(inout x25_pkg::fe_t ax, inout x25_pkg::fe_t az,
                                        inout x25_pkg::fe_t bx, inout x25_pkg::fe_t bz,
                                        input x25_pkg::fe_t base);
        x25_pkg::fe_t m, n, s, d, nx, nz;
        m = fe_mul_mod(fe_sub_mod(ax, az), fe_add_mod(bx, bz));
        n = fe_mul_mod(fe_add_mod(ax, az), fe_sub_mod(bx, bz));
        s = fe_add_mod(m, n);
        d = fe_sub_mod(m, n);
        point_double(nx, nz, bx, bz);
        ax = fe_mul_mod(s, s);
        az = fe_mul_mod(fe_mul_mod(d, d), base);
        bx = nx;
        bz = nz;
    endfunction

    function automatic x25_pkg::fe_t scalar_multiple_x(x25_pkg::fe_t point,
                                                       x25_pkg::fe_t scalar);
        x25_pkg::fe_t base, px, pz, qx, qz, inv;
        int  top;
        top  = -1;
        // The base may lie at or above 2p, so up to two subtractions are needed.
        base = point;
        if (base >= x25_pkg::PRIME)
            base = base - x25_pkg::PRIME;
        if (base >= x25_pkg::PRIME)
            base = base - x25_pkg::PRIME;
        for (int i = 255; i >= 0; i--)
        begin
            if (scalar[i] && top < 0)
                top = i;
        end
        if (top < 0)
            return '0;
        px = base;
        pz = 256'd1;
        point_double(qx, qz, px, pz);
        for (int i = top - 1; i >= 0; i--)
        begin
            if (scalar[i])
                ladder_rung(px, pz, qx, qz, base);
            else
                ladder_rung(qx, qz, px, pz, base);
        end
        // Fermat inverse; a zero Z stays zero.
        inv = 256'd1;
        for (int b = 254; b >= 0; b--)
        begin
            inv = fe_mul_mod(inv, inv);
            if (b != 2 && b != 4)
                inv = fe_mul_mod(inv, pz);
        end
        return fe_mul_mod(px, inv);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        x25_pkg::fe_t r;
        result_beat_t b;
        if (!rst_n)
        begin
            fail_count = 0;
            pending    = 0;
            expected_beats.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                point_words[word_index]  = point_word;
                scalar_words[word_index] = scalar_word;
                if (word_index == 2'd3)
                begin
                    r = scalar_multiple_x({point_words[3], point_words[2], point_words[1],
                                           point_words[0]},
                                          {scalar_words[3], scalar_words[2],
                                           scalar_words[1], scalar_words[0]});
                    for (int k = 0; k < 4; k++)
                    begin
                        b.word  = r[64*k +: 64];
                        b.index = 2'(k);
                        b.last  = (k == 3);
                        expected_beats.push_back(b);
                    end
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected result beat word=%h index=%0d last=%0b",
                             $time, result_word, result_index, result_last);
                    fail_count++;
                end
                else
                begin
                    b = expected_beats.pop_front();
                    if (result_word !== b.word)
                    begin
                        $display("%0t: result_word expected %h actual %h",
                                 $time, b.word, result_word);
                        fail_count++;
                    end
                    if (result_index !== b.index)
                    begin
                        $display("%0t: result_index expected %0d actual %0d",
                                 $time, b.index, result_index);
                        fail_count++;
                    end
                    if (result_last !== b.last)
                    begin
                        $display("%0t: result_last expected %0b actual %0b",
                                 $time, b.last, result_last);
                        fail_count++;
                    end
                end
            end
            pending = expected_beats.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
// Top of the X25519 scalar multiply simulation: clock, reset, beat stimulus and verdict.
// Depends on x25_pkg, the block x25519_scalar_multiply and x25519_result_checker.
`timescale 1ns / 1ps

module testbench;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] point_word;
    logic [63:0] scalar_word;
    logic [1:0]  word_index;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] result_word;
    logic [1:0]  result_index;
    logic        result_last;
    int          fail_count;
    int          pending;

    // Counts accepted input beats; the sender idles nowhere inside a middle stretch.
    int          beats_sent;
    // Counts accepted result beats; the receiver stalls nowhere inside a middle stretch.
    int          results_taken;

    x25519_scalar_multiply u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .point_word   (point_word),
        .scalar_word  (scalar_word),
        .word_index   (word_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_word  (result_word),
        .result_index (result_index),
        .result_last  (result_last)
    );

    x25519_result_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .point_word   (point_word),
        .scalar_word  (scalar_word),
        .word_index   (word_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_word  (result_word),
        .result_index (result_index),
        .result_last  (result_last),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Offers one beat and returns at the edge that accepts it. Valid stays high
    // afterward, so back-to-back beats never drop it; only a gap lowers it.
    task automatic send_beat(input logic [63:0] pw, input logic [63:0] sw,
                             input logic [1:0] idx);
        bit quiet;
        quiet = (beats_sent >= 30 && beats_sent < 55);
        if (!quiet && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        point_word  <= pw;
        scalar_word <= sw;
        word_index  <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // A full well-formed load: four word pairs, the last one starts the ladder.
    task automatic load_and_start(input logic [255:0] pt, input logic [255:0] sc);
        for (int i = 0; i < 4; i++)
            send_beat(pt[64*i +: 64], sc[64*i +: 64], 2'(i));
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Receiver: random stalls, a stall-free stretch, and one long hold-off while
    // the first results wait, so the block stays busy and stalls its input.
    initial
    begin
        bit hold_done;
        hold_done     = 1'b0;
        results_taken = 0;
        out_stall     = 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                results_taken++;
            if (out_valid && !hold_done && results_taken > 0)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (4000) @(posedge clk);
            end
            else if (results_taken >= 40 && results_taken < 60)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 23);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [1:0]  idx;
        logic [63:0] sw;
        in_valid    = 1'b0;
        point_word  = '0;
        scalar_word = '0;
        word_index  = '0;
        beats_sent  = 0;
        rst_n       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Base x all ones lies above p and is taken mod p; scalar 1
        // returns the base itself.
        load_and_start({256{1'b1}}, 256'd1);
        // Repeated start: only the last pair is sent, the earlier words are reused.
        send_beat('0, '0, 2'd3);
        // Zero scalar gives a zero result.
        load_and_start({rand_word(), rand_word(), rand_word(), rand_word()}, '0);
        // Base x zero: doubling lands on Z equal to zero, so the result is zero.
        load_and_start('0, 256'd2);
        // The longest ladder: every scalar bit set.
        load_and_start(256'd9, {256{1'b1}});

        // Random part: mostly well-formed loads with random base words and short
        // scalars, the rest loose beats at random positions.
        while (beats_sent < 100)
        begin
            if ($urandom_range(99) < 80)
            begin
                sw = ($urandom_range(9) == 0) ? 64'd0 : 64'($urandom_range(1, 4095));
                load_and_start({rand_word(), rand_word(), rand_word(), rand_word()},
                               {192'd0, sw});
            end
            else
            begin
                idx = 2'($urandom_range(3));
                sw  = (idx == 2'd0) ? 64'($urandom_range(255)) : 64'd0;
                send_beat(rand_word(), sw, idx);
            end
        end
        in_valid <= 1'b0;

        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run (one full-length ladder plus
    // about twenty short ones with their inverses, under random stalls).
    initial
    begin
        #400000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
